// ===== sv/mbd_pkg.sv =====
// Shared constants, opcodes and the queue word type for the mip box downscaler.
// No dependencies.
package mbd_pkg;

    localparam int MAX_SIZE   = 1024;
    localparam int CFG_W      = 11;
    localparam int CNT_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W     = CNT_W + 1;
    localparam int LINE_DEPTH = MAX_SIZE / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int SUM_W      = CHAN_W + 1;
    localparam int LINE_W     = 3 * SUM_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // back-end operations
    localparam logic [1:0] OP_WRITE  = 2'd0;  // store even-row pair sums
    localparam logic [1:0] OP_READ   = 2'd1;  // combine with stored sums, emit
    localparam logic [1:0] OP_DIRECT = 2'd2;  // emit data as given

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [LINE_W-1:0] data;
        logic              last;
    } q_word_t;

endpackage

// ===== sv/mbd_queue.sv =====
// Short FIFO of work words between the front end and the back end.
// Depends on mbd_pkg.
module mbd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbd_pkg::q_word_t push_word,
    input  logic             pop,
    output mbd_pkg::q_word_t pop_word,
    output logic             full,
    output logic             empty
);

    mbd_pkg::q_word_t            slot_reg [mbd_pkg::Q_DEPTH];
    logic [mbd_pkg::Q_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mbd_pkg::Q_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mbd_pkg::Q_AW:0]      count_reg, count_next;

    assign full     = (count_reg == (mbd_pkg::Q_AW+1)'(mbd_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mbd_pkg::Q_AW'(mbd_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mbd_pkg::Q_AW'(mbd_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule

// ===== sv/mbd_front.sv =====
// Front end: configuration, position counters, left-pixel hold and pair sums.
// Classifies each source word and pushes work words into the queue. Uses mbd_pkg.
module mbd_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]    s_tdata,
    input  logic                         q_full,
    output logic                         q_push,
    output mbd_pkg::q_word_t             q_word
);

    localparam int EXT_W = (mbd_pkg::CFG_W > mbd_pkg::SIZE_W) ?
                           mbd_pkg::CFG_W : mbd_pkg::SIZE_W;

    logic [mbd_pkg::SIZE_W-1:0] width_reg, height_reg;
    logic [mbd_pkg::CNT_W-1:0]  col_reg, col_next;
    logic [mbd_pkg::CNT_W-1:0]  row_reg, row_next;
    logic [mbd_pkg::PIX_W-1:0]  held_reg, held_next;

    logic [EXT_W-1:0]           cfg_ext;
    logic [mbd_pkg::SIZE_W-1:0] cfg_eff;
    logic [mbd_pkg::SIZE_W-1:0] col_ext, row_ext, col_inc, row_inc;
    logic [mbd_pkg::SIZE_W-1:0] last_col, last_row;
    logic                       one_w, one_h;
    logic                       accept;
    logic [mbd_pkg::LINE_W-1:0] pair_sums;
    logic [mbd_pkg::PIX_W-1:0]  pair_avg;
    logic                       pos_odd, pos_last;

    // clamp the written size into 1..MAX_SIZE
    always_comb
    begin
        cfg_ext = EXT_W'(cfg_data);
        if (cfg_ext == '0)
        begin
            cfg_eff = mbd_pkg::SIZE_W'(1);
        end
        else if (cfg_ext > EXT_W'(mbd_pkg::MAX_SIZE))
        begin
            cfg_eff = mbd_pkg::SIZE_W'(mbd_pkg::MAX_SIZE);
        end
        else
        begin
            cfg_eff = mbd_pkg::SIZE_W'(cfg_ext);
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        col_ext  = mbd_pkg::SIZE_W'(col_reg);
        row_ext  = mbd_pkg::SIZE_W'(row_reg);
        col_inc  = col_ext + 1'b1;
        row_inc  = row_ext + 1'b1;
        last_col = {width_reg[mbd_pkg::SIZE_W-1:1], 1'b0} - 1'b1;
        last_row = {height_reg[mbd_pkg::SIZE_W-1:1], 1'b0} - 1'b1;
        one_w    = (width_reg == mbd_pkg::SIZE_W'(1));
        one_h    = (height_reg == mbd_pkg::SIZE_W'(1));

        for (int k = 0; k < 3; k++)
        begin
            pair_sums[k*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] =
                mbd_pkg::SUM_W'(held_reg[k*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]) +
                mbd_pkg::SUM_W'(s_tdata[k*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]);
            pair_avg[k*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] =
                pair_sums[k*mbd_pkg::SUM_W + 1 +: mbd_pkg::CHAN_W];
        end

        // single row pairs along columns, single column pairs along rows
        pos_odd  = one_h ? col_reg[0] : (one_w ? row_reg[0] : col_reg[0]);
        pos_last = one_h ? (col_ext == last_col) : (row_ext == last_row);

        held_next    = held_reg;
        q_push       = 1'b0;
        q_word.op    = mbd_pkg::OP_DIRECT;
        q_word.slot  = mbd_pkg::SLOT_W'(col_reg >> 1);
        q_word.data  = mbd_pkg::LINE_W'(pair_avg);
        q_word.last  = 1'b0;

        if (one_w && one_h)
        begin
            q_push      = accept;
            q_word.data = '0;
            q_word.last = 1'b1;
        end
        else if (!pos_odd)
        begin
            if (accept)
            begin
                held_next = s_tdata;
            end
        end
        else if (one_w || one_h)
        begin
            q_push      = accept;
            q_word.last = pos_last;
        end
        else
        begin
            q_push      = accept;
            q_word.data = pair_sums;
            q_word.op   = row_reg[0] ? mbd_pkg::OP_READ : mbd_pkg::OP_WRITE;
            q_word.last = (col_ext == last_col) && (row_ext == last_row);
        end

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = (row_inc >= height_reg) ? '0 : mbd_pkg::CNT_W'(row_inc);
            end
            else
            begin
                col_next = mbd_pkg::CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbd_pkg::SIZE_W'(1);
            height_reg <= mbd_pkg::SIZE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mbd_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_eff;
            end
            else
            begin
                height_reg <= cfg_eff;
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== sv/mbd_back.sv =====
// Back end: pair-sum line buffer, final averaging and the output register.
// Drains work words from the queue. Uses mbd_pkg.
module mbd_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  mbd_pkg::q_word_t             q_word,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbd_pkg::PIX_W-1:0]    m_tdata,
    output logic                         m_tlast
);

    logic [mbd_pkg::LINE_W-1:0] line_mem [mbd_pkg::LINE_DEPTH];
    logic [mbd_pkg::LINE_W-1:0] rd_data_reg;

    logic                       s1_valid_reg, s1_valid_next;
    logic [1:0]                 s1_op_reg;
    logic [mbd_pkg::LINE_W-1:0] s1_data_reg;
    logic                       s1_last_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [mbd_pkg::PIX_W-1:0]  out_data_reg, out_data_next;
    logic                       out_last_reg;

    logic                       out_free, s1_adv;
    logic [mbd_pkg::SUM_W:0]    quad;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = !s1_valid_reg || out_free;
    assign q_pop    = !q_empty && s1_adv;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (q_pop && (q_word.op != mbd_pkg::OP_WRITE))
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

        quad = '0;
        for (int k = 0; k < 3; k++)
        begin
            quad = (mbd_pkg::SUM_W+1)'(rd_data_reg[k*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]) +
                   (mbd_pkg::SUM_W+1)'(s1_data_reg[k*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]);
            out_data_next[k*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] =
                (s1_op_reg == mbd_pkg::OP_READ) ? quad[2 +: mbd_pkg::CHAN_W] :
                s1_data_reg[k*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_op_reg   <= q_word.op;
            s1_data_reg <= q_word.data;
            s1_last_reg <= q_word.last;
        end
        if (out_free && s1_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= s1_last_reg;
        end
    end

    // line buffer: at most one access per popped word, read data registered
    always_ff @(posedge clk)
    begin
        if (q_pop && (q_word.op == mbd_pkg::OP_WRITE))
        begin
            line_mem[q_word.slot] <= q_word.data;
        end
        if (q_pop && (q_word.op == mbd_pkg::OP_READ))
        begin
            rd_data_reg <= line_mem[q_word.slot];
        end
    end

`ifndef SYNTHESIS
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("stage one word lost under stall");
    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !q_pop)
        else $error("pop while stage one is stalled");
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !s1_valid_reg) |=> !out_valid_reg)
        else $error("output word appeared without a stage one word");
`endif

endmodule

// ===== sv/mipmap_box_downscale_rgb.sv =====
// Top level of the 2x2 box-filter mip downscaler for RGB888 pixels.
// Instantiates mbd_front, mbd_queue and mbd_back; uses mbd_pkg.
//
// Source pixels enter in raster order, one word per cycle while the queue is
// not full, and the next smaller mip level leaves in raster order, tlast on
// its final pixel. A result passes the queue write, the line-buffer access
// and the output register after the source word that completes it, and is
// held while the output side stalls; each pixel pair costs at most one access
// of the single-port pair-sum line buffer in the back end. A four-word queue
// parts the pixel classifier from the line buffer so either side may stall on
// its own. Sizes are clamped to 1..MAX_SIZE, and writing either size register
// restarts at the first pixel of a new image; write sizes only while the block
// is idle. The line buffer needs no clearing after reset.
module mipmap_box_downscale_rgb
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mbd_pkg::PIX_W-1:0]    s_tdata,   // red_in, green_in, blue_in
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbd_pkg::PIX_W-1:0]    m_tdata,   // red_out, green_out, blue_out
    output logic                         m_tlast    // last_pixel
);

    logic             q_push, q_pop, q_full, q_empty;
    mbd_pkg::q_word_t q_in_word, q_out_word;

    mbd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_word   (q_in_word)
    );

    mbd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_word(q_in_word),
        .pop      (q_pop),
        .pop_word (q_out_word),
        .full     (q_full),
        .empty    (q_empty)
    );

    mbd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_word   (q_out_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
